// ===== rtl/cltok_pkg.sv =====
// Shared types and constants of the command line tokenizer.
package cltok_pkg;

   // Largest token count and token storage that the block ever uses.
   localparam logic [10:0] MAX_TOKENS = 11'd1024;
   localparam logic [13:0] BUF_BYTES  = 14'd9216;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [1:0] CSR_LITERAL_QUOTES = 2'd0;
   localparam logic [1:0] CSR_TOKEN_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_BUFFER_BUDGET  = 2'd2;

   // Most results that one input byte can cause.
   localparam int MAX_RESULTS = 3;

   typedef enum logic [2:0] {
      MODE_BETWEEN,
      MODE_TOKEN,
      MODE_QUOTED,
      MODE_COMMENT,
      MODE_CSTAR,
      MODE_DRAIN
   } mode_type;

   typedef enum logic [2:0] {
      KIND_BYTE  = 3'd0,
      KIND_END   = 3'd1,
      KIND_DONE  = 3'd2,
      KIND_LIMIT = 3'd3,
      KIND_BUF   = 3'd4
   } kind_type;

   typedef struct packed {
      mode_type    mode;
      logic        held_slash;
      logic [10:0] tokens_done;
      logic [13:0] bytes_left;
   } parse_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [9:0] token_number;
   } result_type;

   // All results of one input byte; count is zero when the byte causes none.
   typedef struct packed {
      logic [1:0]                         count;
      result_type [MAX_RESULTS-1:0] results;
   } entry_type;

endpackage

// ===== rtl/cltok_front.sv =====
// Front end: configuration registers, parse state and per-byte classification.
module cltok_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_char_code,
   input  logic                 req_end_of_text,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [13:0]          csr_write_data,
   input  logic                 queue_full,
   output logic                 push,
   output cltok_pkg::entry_type push_entry
);

   localparam int FEED_PASSES = 3;
   localparam logic [10:0] LIMIT_RESET =
      (11'd1024 > cltok_pkg::MAX_TOKENS) ? cltok_pkg::MAX_TOKENS : 11'd1024;
   localparam logic [13:0] BUDGET_RESET =
      (14'd9216 > cltok_pkg::BUF_BYTES) ? cltok_pkg::BUF_BYTES : 14'd9216;

   typedef struct packed {
      cltok_pkg::parse_state_type st;
      cltok_pkg::entry_type       out;
   } work_type;

   cltok_pkg::parse_state_type state_ff, state_in;
   logic                       literal_quotes_ff, literal_quotes_in;
   logic [10:0]                limit_ff, limit_in;
   logic [13:0]                budget_ff, budget_in;
   logic                       accept;
   work_type                   step;

   function automatic work_type add_result(input work_type w, input cltok_pkg::kind_type kind,
                                           input logic [7:0] data);
      work_type r;
      r = w;
      if (r.out.count < 2'(cltok_pkg::MAX_RESULTS)) begin
         r.out.results[r.out.count].kind = kind;
         r.out.results[r.out.count].data_byte = data;
         r.out.results[r.out.count].token_number = r.st.tokens_done[9:0];
         r.out.count = r.out.count + 2'd1;
      end
      return r;
   endfunction

   function automatic work_type stop(input work_type w, input cltok_pkg::kind_type kind);
      work_type r;
      r = add_result(w, kind, 8'd0);
      r.st.mode = cltok_pkg::MODE_DRAIN;
      r.st.held_slash = 1'b0;
      return r;
   endfunction

   function automatic work_type copy_byte(input work_type w, input logic [7:0] c);
      work_type r;
      r = w;
      if (r.st.bytes_left <= 14'd1) begin
         r = stop(r, cltok_pkg::KIND_BUF);
      end else begin
         r.st.bytes_left = r.st.bytes_left - 14'd1;
         r = add_result(r, cltok_pkg::KIND_BYTE, c);
      end
      return r;
   endfunction

   // On success the mode is left at between tokens, on failure it drains.
   function automatic work_type close_token(input work_type w);
      work_type r;
      r = w;
      r.st.held_slash = 1'b0;
      if (r.st.bytes_left <= 14'd2) begin
         r = stop(r, cltok_pkg::KIND_BUF);
      end else begin
         r.st.bytes_left = r.st.bytes_left - 14'd1;
         r = add_result(r, cltok_pkg::KIND_END, 8'd0);
         r.st.tokens_done = r.st.tokens_done + 11'd1;
         r.st.mode = cltok_pkg::MODE_BETWEEN;
      end
      return r;
   endfunction

   function automatic work_type close_done(input work_type w);
      work_type r;
      r = w;
      if (r.st.bytes_left <= 14'd2) begin
         r = stop(r, cltok_pkg::KIND_BUF);
      end else begin
         r.st.bytes_left = r.st.bytes_left - 14'd1;
         r.st.tokens_done = r.st.tokens_done + 11'd1;
         r = stop(r, cltok_pkg::KIND_DONE);
      end
      return r;
   endfunction

   function automatic work_type run_step(input cltok_pkg::parse_state_type s, input logic [7:0] c,
                                         input logic eot, input logic iq,
                                         input logic [10:0] lim, input logic [13:0] bud);
      work_type w;
      logic     again;
      logic     quote;
      logic     go_on;
      w.st = s;
      w.out = '0;
      quote = (c == cltok_pkg::CH_QUOTE) && !iq;
      again = (c != 8'd0);
      go_on = 1'b1;
      // A byte passes through at most three mode decisions before it settles.
      for (int p = 0; p < FEED_PASSES; p++) begin
         if (again) begin
            again = 1'b0;
            case (w.st.mode)
               cltok_pkg::MODE_BETWEEN: begin
                  if (w.st.tokens_done >= lim) begin
                     w = stop(w, cltok_pkg::KIND_LIMIT);
                  end else if (w.st.held_slash) begin
                     w.st.held_slash = 1'b0;
                     if (c == cltok_pkg::CH_SLASH) begin
                        w = stop(w, cltok_pkg::KIND_DONE);
                     end else if (c == cltok_pkg::CH_STAR) begin
                        w.st.mode = cltok_pkg::MODE_CSTAR;
                     end else begin
                        w.st.mode = cltok_pkg::MODE_TOKEN;
                        w = copy_byte(w, cltok_pkg::CH_SLASH);
                        again = (w.st.mode == cltok_pkg::MODE_TOKEN);
                     end
                  end else if (c <= cltok_pkg::CH_SPACE) begin
                     w.st.mode = cltok_pkg::MODE_BETWEEN;
                  end else if (c == cltok_pkg::CH_SLASH) begin
                     w.st.held_slash = 1'b1;
                  end else if (quote) begin
                     w.st.mode = cltok_pkg::MODE_QUOTED;
                  end else begin
                     w.st.mode = cltok_pkg::MODE_TOKEN;
                     again = 1'b1;
                  end
               end
               cltok_pkg::MODE_TOKEN: begin
                  go_on = 1'b1;
                  if (w.st.held_slash) begin
                     if (c == cltok_pkg::CH_SLASH || c == cltok_pkg::CH_STAR) begin
                        // The held slash may open a comment, so the token ends here.
                        w = close_token(w);
                        if (w.st.mode == cltok_pkg::MODE_BETWEEN) begin
                           w.st.held_slash = 1'b1;
                           again = 1'b1;
                        end
                        go_on = 1'b0;
                     end else begin
                        w.st.held_slash = 1'b0;
                        w = copy_byte(w, cltok_pkg::CH_SLASH);
                        go_on = (w.st.mode == cltok_pkg::MODE_TOKEN);
                     end
                  end
                  if (go_on) begin
                     if (c <= cltok_pkg::CH_SPACE || quote) begin
                        w = close_token(w);
                        again = (w.st.mode == cltok_pkg::MODE_BETWEEN);
                     end else if (c == cltok_pkg::CH_SLASH) begin
                        w.st.held_slash = 1'b1;
                     end else begin
                        w = copy_byte(w, c);
                     end
                  end
               end
               cltok_pkg::MODE_QUOTED: begin
                  if (c == cltok_pkg::CH_QUOTE) begin
                     w = close_token(w);
                     if (w.st.mode == cltok_pkg::MODE_BETWEEN && w.st.tokens_done >= lim) begin
                        w = stop(w, cltok_pkg::KIND_LIMIT);
                     end
                  end else begin
                     w = copy_byte(w, c);
                  end
               end
               cltok_pkg::MODE_COMMENT, cltok_pkg::MODE_CSTAR: begin
                  if (c == cltok_pkg::CH_SLASH && w.st.mode == cltok_pkg::MODE_CSTAR) begin
                     w.st.mode = cltok_pkg::MODE_BETWEEN;
                  end else if (c == cltok_pkg::CH_STAR) begin
                     w.st.mode = cltok_pkg::MODE_CSTAR;
                  end else begin
                     w.st.mode = cltok_pkg::MODE_COMMENT;
                  end
               end
               default: begin
                  w.st.mode = w.st.mode;
               end
            endcase
         end
      end
      // End of string: finish what is open, then start the next string afresh.
      if (c == 8'd0 || eot) begin
         case (w.st.mode)
            cltok_pkg::MODE_BETWEEN: begin
               if (w.st.held_slash) begin
                  w.st.held_slash = 1'b0;
                  w.st.mode = cltok_pkg::MODE_TOKEN;
                  w = copy_byte(w, cltok_pkg::CH_SLASH);
                  if (w.st.mode == cltok_pkg::MODE_TOKEN) begin
                     w = close_done(w);
                  end
               end else if (w.st.tokens_done >= lim) begin
                  w = stop(w, cltok_pkg::KIND_LIMIT);
               end else begin
                  w = stop(w, cltok_pkg::KIND_DONE);
               end
            end
            cltok_pkg::MODE_TOKEN: begin
               go_on = 1'b1;
               if (w.st.held_slash) begin
                  w.st.held_slash = 1'b0;
                  w = copy_byte(w, cltok_pkg::CH_SLASH);
                  go_on = (w.st.mode == cltok_pkg::MODE_TOKEN);
               end
               if (go_on) begin
                  w = close_done(w);
               end
            end
            cltok_pkg::MODE_QUOTED: begin
               w = close_done(w);
            end
            cltok_pkg::MODE_COMMENT, cltok_pkg::MODE_CSTAR: begin
               w = stop(w, cltok_pkg::KIND_DONE);
            end
            default: begin
               w.st.mode = w.st.mode;
            end
         endcase
         w.st.mode = cltok_pkg::MODE_BETWEEN;
         w.st.held_slash = 1'b0;
         w.st.tokens_done = 11'd0;
         w.st.bytes_left = bud;
      end
      return w;
   endfunction

   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;

   always_comb begin
      step = run_step(state_ff, req_char_code, req_end_of_text, literal_quotes_ff,
                      limit_ff, budget_ff);
      push = accept && (step.out.count != 2'd0);
      push_entry = step.out;
   end

   always_comb begin
      state_in = state_ff;
      literal_quotes_in = literal_quotes_ff;
      limit_in = limit_ff;
      budget_in = budget_ff;
      if (accept) begin
         state_in = step.st;
      end
      if (csr_write_enable) begin
         case (csr_index)
            cltok_pkg::CSR_LITERAL_QUOTES: begin
               literal_quotes_in = csr_write_data[0];
            end
            cltok_pkg::CSR_TOKEN_LIMIT: begin
               limit_in = (csr_write_data[10:0] > cltok_pkg::MAX_TOKENS) ?
                          cltok_pkg::MAX_TOKENS : csr_write_data[10:0];
            end
            cltok_pkg::CSR_BUFFER_BUDGET: begin
               budget_in = (csr_write_data > cltok_pkg::BUF_BYTES) ?
                           cltok_pkg::BUF_BYTES : csr_write_data;
               state_in.bytes_left = budget_in;
            end
            default: begin
               budget_in = budget_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode <= cltok_pkg::MODE_BETWEEN;
         state_ff.held_slash <= 1'b0;
         state_ff.tokens_done <= 11'd0;
         state_ff.bytes_left <= BUDGET_RESET;
         literal_quotes_ff <= 1'b0;
         limit_ff <= LIMIT_RESET;
         budget_ff <= BUDGET_RESET;
      end else begin
         state_ff <= state_in;
         literal_quotes_ff <= literal_quotes_in;
         limit_ff <= limit_in;
         budget_ff <= budget_in;
      end
   end

endmodule

// ===== rtl/cltok_queue.sv =====
// Short register queue of classified result groups between front and back ends.
module cltok_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cltok_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output cltok_pkg::entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cltok_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/cltok_back.sv =====
// Back end: sends the queued results one beat at a time through an output register.
module cltok_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  cltok_pkg::entry_type head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_kind,
   output logic [7:0]           rsp_data_byte,
   output logic [9:0]           rsp_token_number,
   output logic                 rsp_last
);

   logic                   valid_ff, valid_in;
   cltok_pkg::result_type  result_ff, result_in;
   logic                   last_ff, last_in;
   logic [1:0]             sub_ff, sub_in;
   logic                   out_free;
   logic                   take;
   logic                   final_one;

   assign out_free = !valid_ff || !rsp_stall;
   assign take = out_free && not_empty;
   assign final_one = (sub_ff == head.count - 2'd1);
   assign pop = take && final_one;

   always_comb begin
      valid_in = valid_ff;
      result_in = result_ff;
      last_in = last_ff;
      sub_in = sub_ff;
      if (take) begin
         valid_in = 1'b1;
         result_in = head.results[sub_ff];
         last_in = final_one;
         sub_in = final_one ? 2'd0 : sub_ff + 2'd1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = result_ff.kind;
   assign rsp_data_byte = result_ff.data_byte;
   assign rsp_token_number = result_ff.token_number;
   assign rsp_last = last_ff;

endmodule

// ===== rtl/command_line_tokenizer.sv =====
// Command line tokenizer: splits a byte stream into token bytes and token ends.
//
// The req channel takes one text byte per beat with an end_of_text flag; a zero
// byte also ends the string. The rsp channel gives token bytes (kind 0), token
// ends (kind 1) and exactly one done, token limit error or buffer error per
// string; rsp_last marks the final result caused by one input byte.
// Each accepted byte is classified combinationally by the front end and its
// zero to three results enter a queue of QUEUE_DEPTH groups; the first result
// reaches rsp through the queue entry and then the output register. A byte is
// taken every cycle as long as the queue has room, so the sustained rate is one
// byte per cycle while results average at most one per byte; the rsp register
// sends one result per cycle unless rsp_stall is high, pacing bytes with more.
// When rsp_stall is high the output register holds its result, the queue fills
// and then req_stall rises. Reset empties the queue, clears the output and sets
// the registers to quotes honored, 1024 tokens and 9216 bytes of budget.
// The csr port writes a register; users must use it only while idle, unchecked.
module command_line_tokenizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_token_number,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_write_data
);

   logic                 push;
   cltok_pkg::entry_type push_entry;
   logic                 queue_full;
   logic                 pop;
   logic                 not_empty;
   cltok_pkg::entry_type head;

   cltok_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_end_of_text  (req_end_of_text),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   cltok_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   cltok_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_token_number (rsp_token_number),
      .rsp_last         (rsp_last)
   );

endmodule
